// ----- sv/b2pbcd_pkg.sv -----
// ----------------------------------------------------------------------------
// b2pbcd_pkg: shared types and constants for the binary to packed BCD block
// Holds the datapath sizes and the command code that drives each digit cell.
// ----------------------------------------------------------------------------
package b2pbcd_pkg;

    // Digits kept by the cell chain (2..20); 20 digits hold any 64-bit value
    localparam int MAX_DIGITS = 20;
    // Width of the binary input word
    localparam int VAL_W      = 64;
    // Width of the bit counter used during conversion
    localparam int CNT_W      = $clog2(VAL_W);
    // Width of the digit count input
    localparam int CNT_IN_W   = 5;
    // Width of the byte index output
    localparam int IDX_W      = 4;
    // Bytes produced at the largest digit count
    localparam int MAX_BYTES  = (MAX_DIGITS + 1) / 2;

    // Command sent to every digit cell each cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_SHIFT,
        CELL_DROP
    } t_cell_op;

endpackage

// ----- sv/b2pbcd_cell.sv -----
// ----------------------------------------------------------------------------
// b2pbcd_cell: one decimal digit of the shift-and-add-3 chain
// Holds a BCD digit, adds three when it is five or more, shifts one bit in
// from the lower neighbor and passes its top bit to the upper neighbor.
// In drop mode it takes the digit two places above to stream out pairs.
// ----------------------------------------------------------------------------
module b2pbcd_cell (
    input  logic                 i_clk,
    input  b2pbcd_pkg::t_cell_op i_op,
    input  logic                 i_bit,
    input  logic [3:0]           i_down,
    output logic [3:0]           o_digit,
    output logic                 o_carry
);
    import b2pbcd_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] adj;

    // Correct the digit before the doubling step
    assign adj     = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_carry = adj[3];
    assign o_digit = r_digit;

    // Select the next digit from the command
    always_comb begin
        case (i_op)
            CELL_CLEAR: n_digit = 4'd0;
            CELL_SHIFT: n_digit = {adj[2:0], i_bit};
            CELL_DROP:  n_digit = i_down;
            default:    n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ----- sv/binary_to_packed_bcd.sv -----
// ----------------------------------------------------------------------------
// binary_to_packed_bcd: 64-bit binary to packed BCD converter
// A chain of digit cells runs shift-and-add-3, one input bit per cycle, then
// streams the lowest digits out two at a time as packed BCD words.
// ----------------------------------------------------------------------------
// Steps: start is taken only in idle; one load step clears the cells and loads the value,
// then all 64 input bits shift through the cell chain, then ceil(n/2) words go out
// (n = count saturated to 20). A count of zero skips the conversion and stays idle.
// One word per cycle while emitting; the receiver cannot stall.
// Synchronous active-low reset returns the controller to idle, no strobe.
module binary_to_packed_bcd (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [b2pbcd_pkg::VAL_W-1:0]        i_value,
    input  logic [b2pbcd_pkg::CNT_IN_W-1:0]     i_digit_count,
    output logic                                o_strobe,
    output logic [7:0]                          o_bcd_byte,
    output logic [b2pbcd_pkg::IDX_W-1:0]        o_byte_index,
    output logic                                o_last
);
    import b2pbcd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [VAL_W-1:0]    r_val, n_val;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [IDX_W-1:0]    r_bytes, n_bytes;
    logic                r_odd, n_odd;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_strobe, n_strobe;
    logic [7:0]          r_byte, n_byte;
    logic [IDX_W-1:0]    r_oidx, n_oidx;
    logic                r_last, n_last;

    t_cell_op            cell_op;
    logic [3:0]          digit [MAX_DIGITS];
    logic                carry [MAX_DIGITS+1];

    logic                accept;
    logic [CNT_IN_W-1:0] sat_n;
    logic [CNT_IN_W:0]   sum_n;
    logic                is_last;

    assign accept   = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);
    assign carry[0] = r_val[VAL_W-1];

    // Saturate the count and derive the byte total
    assign sat_n = (i_digit_count > CNT_IN_W'(MAX_DIGITS)) ? CNT_IN_W'(MAX_DIGITS)
                                                           : i_digit_count;
    assign sum_n = {1'b0, sat_n} + (CNT_IN_W+1)'(1);
    assign is_last = (r_idx == (r_bytes - IDX_W'(1)));

    // Build the digit chain
    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        logic [3:0] down;
        if (g + 2 < MAX_DIGITS) begin : g_dn
            assign down = digit[g+2];
        end else begin : g_top
            assign down = 4'd0;
        end
        b2pbcd_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_bit   (carry[g]),
            .i_down  (down),
            .o_digit (digit[g]),
            .o_carry (carry[g+1])
        );
    end

    // Sequence conversion and emission
    always_comb begin
        n_state  = r_state;
        n_val    = r_val;
        n_cnt    = r_cnt;
        n_bytes  = r_bytes;
        n_odd    = r_odd;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_byte   = r_byte;
        n_oidx   = r_oidx;
        n_last   = r_last;
        cell_op  = CELL_HOLD;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_val   = i_value;
                    n_cnt   = '0;
                    n_idx   = '0;
                    n_bytes = IDX_W'(sum_n >> 1);
                    n_odd   = sat_n[0];
                    cell_op = CELL_CLEAR;
                    n_state = (sat_n == '0) ? ST_IDLE : ST_CONV;
                end
            end
            ST_CONV: begin
                cell_op = CELL_SHIFT;
                n_val   = {r_val[VAL_W-2:0], 1'b0};
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VAL_W - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cell_op  = CELL_DROP;
                n_strobe = 1'b1;
                n_byte   = {(r_odd && is_last) ? 4'd0 : digit[1], digit[0]};
                n_oidx   = r_idx;
                n_last   = is_last;
                n_idx    = r_idx + IDX_W'(1);
                if (is_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_cnt   <= n_cnt;
        r_bytes <= n_bytes;
        r_odd   <= n_odd;
        r_idx   <= n_idx;
        r_byte  <= n_byte;
        r_oidx  <= n_oidx;
        r_last  <= n_last;
    end

    assign o_strobe     = r_strobe;
    assign o_bcd_byte   = r_byte;
    assign o_byte_index = r_oidx;
    assign o_last       = r_last;

`ifndef SYNTHESIS
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_EMIT))
        else $error("word strobed without emit phase");
    a_zero_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_digit_count == '0)) |=> !busy)
        else $error("zero count did not return to idle");
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_byte_index < IDX_W'(MAX_BYTES)))
        else $error("byte index out of range");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> (r_state == ST_IDLE))
        else $error("last word strobed while still busy");
`endif

endmodule

// ----- test/tb_binary_to_packed_bcd.sv -----
// ----------------------------------------------------------------------------
// tb_binary_to_packed_bcd: self-checking bench for the packed BCD converter
// Feeds 64-bit values with digit counts through the start/busy handshake,
// predicts every packed BCD word in the bench, and checks each strobed word
// against the oldest prediction. Directed corner values come first, then
// random values with random sender gaps and a full drain before some items.
// ----------------------------------------------------------------------------
module tb_binary_to_packed_bcd;
    import b2pbcd_pkg::*;

    localparam int SETTLE_CYCLES = 100;   // settle time after the last word before the final check
    localparam int QUIET_LIMIT   = 2000;  // cycles without a handshake or a strobe before timeout
    localparam int RANDOM_ITEMS  = 200;
    localparam int CALM_TAIL     = 40;    // last random items offered with no sender gap

    typedef struct {
        logic [VAL_W-1:0]    value;
        logic [CNT_IN_W-1:0] count;
        int                  gap;
        bit                  drain;
    } t_conv_req;

    typedef struct {
        logic [7:0]       bcd;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_bcd_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [VAL_W-1:0]    i_value = '0;
    logic [CNT_IN_W-1:0] i_digit_count = '0;
    logic                o_strobe;
    logic [7:0]          o_bcd_byte;
    logic [IDX_W-1:0]    o_byte_index;
    logic                o_last;

    t_conv_req conv_reqs[$];
    t_bcd_word bcd_owed[$];

    int  words_predicted = 0;
    int  words_seen = 0;
    int  values_taken = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  gap_left = 0;
    bit  gap_loaded = 1'b0;
    bit  taken;
    int  zero_counts = 0;
    int  saturated_counts = 0;
    int  drains = 0;

    binary_to_packed_bcd uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_digit_count (i_digit_count),
        .o_strobe      (o_strobe),
        .o_bcd_byte    (o_bcd_byte),
        .o_byte_index  (o_byte_index),
        .o_last        (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Split the value into its lowest decimal digits and queue the packed words
    function automatic void predict_bcd_words(logic [VAL_W-1:0] value,
                                              logic [CNT_IN_W-1:0] count);
        logic [VAL_W-1:0] rest;
        logic [3:0]       lo;
        logic [3:0]       hi;
        int               ndig;
        int               nbytes;
        t_bcd_word        w;
        rest   = value;
        ndig   = (count > MAX_DIGITS) ? MAX_DIGITS : int'(count);
        nbytes = (ndig + 1) / 2;
        if (count == 0)
            zero_counts++;
        if (count > MAX_DIGITS)
            saturated_counts++;
        for (int i = 0; i < nbytes; i++) begin
            lo   = 4'(rest % 64'd10);
            rest = rest / 64'd10;
            hi   = 4'd0;
            // an odd count leaves the top nibble of the final word at zero
            if (2 * i + 1 < ndig) begin
                hi   = 4'(rest % 64'd10);
                rest = rest / 64'd10;
            end
            w.bcd  = {hi, lo};
            w.idx  = IDX_W'(i);
            w.last = (i == nbytes - 1);
            bcd_owed.push_back(w);
            words_predicted++;
        end
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    function automatic void add_req(logic [VAL_W-1:0] value, logic [CNT_IN_W-1:0] count,
                                    int gap, bit drain);
        t_conv_req r;
        r.value = value;
        r.count = count;
        r.gap   = gap;
        r.drain = drain;
        if (drain)
            drains++;
        conv_reqs.push_back(r);
    endfunction

    // Driver: offer the oldest pending value, honoring its gap and drain request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                predict_bcd_words(i_value, i_digit_count);
                conv_reqs.delete(0);
                values_taken++;
                gap_loaded = 1'b0;
            end
            if (conv_reqs.size() == 0) begin
                start <= 1'b0;
            end else if (!(start && !taken)) begin
                if (!gap_loaded) begin
                    gap_left   = conv_reqs[0].gap;
                    gap_loaded = 1'b1;
                end
                // count the gap only over cycles in which the block sits idle
                if (gap_left > 0 && !busy && !taken)
                    gap_left--;
                if (gap_left > 0) begin
                    start <= 1'b0;
                end else if (conv_reqs[0].drain && words_seen < words_predicted) begin
                    start <= 1'b0;
                end else begin
                    start         <= 1'b1;
                    i_value       <= conv_reqs[0].value;
                    i_digit_count <= conv_reqs[0].count;
                end
            end
        end
    end

    // Monitor: match each strobed word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            words_seen <= words_seen + 1;
            if (bcd_owed.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual bcd %02h index %0d last %0b",
                         $time, o_bcd_byte, o_byte_index, o_last);
                mismatches++;
            end else begin
                check_field("bcd_byte", bcd_owed[0].bcd, o_bcd_byte);
                check_field("byte_index", bcd_owed[0].idx, o_byte_index);
                check_field("last", bcd_owed[0].last, o_last);
                bcd_owed.delete(0);
            end
        end
    end

    // Watchdog: give up when neither side has moved for too long
    always @(posedge i_clk) begin
        if ((start && !busy && i_rst_n) || o_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no handshake for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [VAL_W-1:0]    v;
        logic [VAL_W-1:0]    pow10;
        logic [CNT_IN_W-1:0] c;
        int                  mode;
        int                  gap;
        int                  pick;

        // Corners: extreme values, odd and even counts, zero and saturated counts
        add_req('0, 5'd20, 0, 1'b0);
        add_req('1, 5'd20, 0, 1'b0);
        add_req('1, 5'd19, 0, 1'b0);
        add_req('1, 5'd1, 0, 1'b0);
        add_req('1, 5'd0, 0, 1'b0);
        add_req(64'd12345, 5'd0, 3, 1'b0);
        add_req('1, 5'd31, 0, 1'b0);
        add_req(64'd9876543210, 5'd21, 0, 1'b0);
        add_req(64'd1234567890, 5'd10, 0, 1'b0);
        add_req(64'd1234567890, 5'd7, 2, 1'b0);
        add_req(64'd5, 5'd20, 0, 1'b0);
        add_req(64'd10000000000000000000, 5'd20, 0, 1'b0);
        add_req(64'd9999999999999999999, 5'd20, 0, 1'b1);
        add_req(64'h8000_0000_0000_0000, 5'd2, 0, 1'b0);
        add_req(64'd99, 5'd2, 0, 1'b0);
        add_req(64'd99, 5'd3, 0, 1'b0);
        add_req(64'h5555_5555_5555_5555, 5'd16, 0, 1'b0);
        add_req(64'hAAAA_AAAA_AAAA_AAAA, 5'd8, 0, 1'b0);
        add_req(64'd1000000000, 5'd9, 0, 1'b0);

        mode = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // switch between idle-heavy and back-to-back stretches
            if (i % 20 == 0)
                mode = $urandom_range(0, 2);
            pick = $urandom_range(0, 9);
            pow10 = 64'd1;
            repeat ($urandom_range(0, 19)) pow10 = pow10 * 64'd10;
            case (pick)
                0, 1, 2, 3: v = {$urandom, $urandom};
                4, 5:       v = 64'($urandom_range(0, 999999));
                6:          v = pow10 + 64'($urandom_range(0, 3)) - 64'd2;
                7:          v = '1 - 64'($urandom_range(0, 1000));
                8:          v = 64'($urandom);
                default:    v = ($urandom_range(0, 1) == 0) ? '0 : pow10;
            endcase
            pick = $urandom_range(0, 15);
            if (pick < 11)
                c = CNT_IN_W'($urandom_range(1, 20));
            else if (pick < 13)
                c = CNT_IN_W'(MAX_DIGITS);
            else if (pick == 13)
                c = '0;
            else
                c = CNT_IN_W'($urandom_range(21, 31));
            gap = 0;
            if (i < RANDOM_ITEMS - CALM_TAIL && mode != 0 && $urandom_range(0, 2) == 0)
                gap = $urandom_range(1, 18);
            add_req(v, c, gap, (i % 50 == 25));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hold until every value is in and every predicted word has come back
        while (conv_reqs.size() > 0 || words_seen < words_predicted)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (bcd_owed.size() != 0) begin
            $display("%0t: %0d predicted words never arrived, expected 0 left, actual %0d",
                     $time, bcd_owed.size(), bcd_owed.size());
            mismatches++;
        end
        $display("Converted %0d values into %0d packed BCD words, %0d mismatches.",
                 values_taken, words_seen, mismatches);
        $display("Covered %0d zero counts, %0d saturated counts, %0d full drains.",
                 zero_counts, saturated_counts, drains);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/b2pbcd_pkg.sv
sv/b2pbcd_cell.sv
sv/binary_to_packed_bcd.sv
test/tb_binary_to_packed_bcd.sv
